@@ design/l2c_pkg.sv @@
// Types, code points and the per-unit decision function of the transliterator.
package l2c_pkg;

  typedef logic [15:0]      unit_t;
  typedef logic [7:0]       ascii_t;
  typedef logic [3:0][15:0] win_t;

  // Result of deciding the unit at the head of the window
  typedef struct packed {
    logic [2:0] used;  // units consumed, zero when the head must wait
    logic [1:0] n;     // results produced, zero to two
    unit_t      e0;
    unit_t      e1;
  } dec_t;

  // ASCII code points
  localparam unit_t U_UP_A  = 16'h0041;
  localparam unit_t U_UP_Z  = 16'h005A;
  localparam unit_t U_LO_A  = 16'h0061;
  localparam unit_t U_LO_Z  = 16'h007A;
  localparam unit_t U_NUL   = 16'h0000;
  localparam unit_t U_SPACE = 16'h0020;
  localparam unit_t U_STOP  = 16'h002E;
  localparam unit_t U_C     = 16'h0063;
  localparam unit_t U_E     = 16'h0065;
  localparam unit_t U_H     = 16'h0068;
  localparam unit_t U_I     = 16'h0069;
  localparam unit_t U_O     = 16'h006F;
  localparam unit_t U_S     = 16'h0073;
  localparam unit_t U_U     = 16'h0075;
  localparam unit_t U_A     = 16'h0061;
  localparam unit_t CASE_SH = 16'h0020;

  // Cyrillic range treated as lower case
  localparam unit_t CYR_LO_FIRST = 16'h0430;
  localparam unit_t CYR_LO_LAST  = 16'h045F;

  // Cyrillic lower-case letters
  localparam unit_t CYR_A     = 16'h0430;
  localparam unit_t CYR_BE    = 16'h0431;
  localparam unit_t CYR_VE    = 16'h0432;
  localparam unit_t CYR_GHE   = 16'h0433;
  localparam unit_t CYR_DE    = 16'h0434;
  localparam unit_t CYR_IE    = 16'h0435;
  localparam unit_t CYR_ZHE   = 16'h0436;
  localparam unit_t CYR_ZE    = 16'h0437;
  localparam unit_t CYR_I     = 16'h0438;
  localparam unit_t CYR_SHORT = 16'h0439;
  localparam unit_t CYR_KA    = 16'h043A;
  localparam unit_t CYR_EL    = 16'h043B;
  localparam unit_t CYR_EM    = 16'h043C;
  localparam unit_t CYR_EN    = 16'h043D;
  localparam unit_t CYR_O     = 16'h043E;
  localparam unit_t CYR_PE    = 16'h043F;
  localparam unit_t CYR_ER    = 16'h0440;
  localparam unit_t CYR_ES    = 16'h0441;
  localparam unit_t CYR_TE    = 16'h0442;
  localparam unit_t CYR_U     = 16'h0443;
  localparam unit_t CYR_EF    = 16'h0444;
  localparam unit_t CYR_HA    = 16'h0445;
  localparam unit_t CYR_TSE   = 16'h0446;
  localparam unit_t CYR_CHE   = 16'h0447;
  localparam unit_t CYR_SHA   = 16'h0448;
  localparam unit_t CYR_SHCHA = 16'h0449;
  localparam unit_t CYR_YERU  = 16'h044B;
  localparam unit_t CYR_SOFT  = 16'h044C;
  localparam unit_t CYR_E_REV = 16'h044D;
  localparam unit_t CYR_YU    = 16'h044E;
  localparam unit_t CYR_YA    = 16'h044F;
  localparam unit_t CYR_YO    = 16'h0451;

  // Cyrillic upper-case letters used directly
  localparam unit_t CYR_UP_YO = 16'h0401;
  localparam unit_t CYR_UP_KA = 16'h041A;
  localparam unit_t CYR_UP_ES = 16'h0421;

  // Fold ASCII upper case to lower case, leave the rest alone
  function automatic unit_t l2c_fold(input unit_t u);
    l2c_fold = (u >= U_UP_A && u <= U_UP_Z) ? unit_t'(u + 16'd32) : u;
  endfunction

  // One-to-one letters; zero for letters that need more thought
  function automatic unit_t l2c_plain(input ascii_t c);
    unit_t r;
    unique case (c)
      "a":     r = CYR_A;
      "b":     r = CYR_BE;
      "d":     r = CYR_DE;
      "f":     r = CYR_EF;
      "g":     r = CYR_GHE;
      "i":     r = CYR_I;
      "l":     r = CYR_EL;
      "m":     r = CYR_EM;
      "n":     r = CYR_EN;
      "o":     r = CYR_O;
      "p":     r = CYR_PE;
      "r":     r = CYR_ER;
      "u":     r = CYR_U;
      "v":     r = CYR_VE;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Decide the unit at the head of a window of wn units
  function automatic dec_t l2c_decide(input win_t q, input logic [2:0] wn,
                                      input logic wend, input logic first);
    dec_t   r;
    logic   up;
    logic   lo;
    logic   av1;
    logic   av2;
    logic   av3;
    logic   low1;
    ascii_t c;
    unit_t  sh;
    unit_t  pm;
    unit_t  f1;
    unit_t  f2;
    unit_t  f3;
    unit_t  want;
    unit_t  hit;
    unit_t  miss;
    unit_t  fh;
    r    = '0;
    r.used = 3'd1;
    r.n    = 2'd1;
    r.e0   = q[0];
    up   = (q[0] >= U_UP_A) && (q[0] <= U_UP_Z);
    lo   = (q[0] >= U_LO_A) && (q[0] <= U_LO_Z);
    av1  = (wn > 3'd1) || wend;
    av2  = (wn > 3'd2) || wend;
    av3  = (wn > 3'd3) || wend;
    f1   = (wn > 3'd1) ? l2c_fold(q[1]) : U_NUL;
    f2   = (wn > 3'd2) ? l2c_fold(q[2]) : U_NUL;
    f3   = (wn > 3'd3) ? l2c_fold(q[3]) : U_NUL;
    low1 = (wn > 3'd1) && (((q[1] >= U_LO_A) && (q[1] <= U_LO_Z)) ||
                           ((q[1] >= CYR_LO_FIRST) && (q[1] <= CYR_LO_LAST)));
    fh   = l2c_fold(q[0]);
    c    = fh[7:0];
    sh   = up ? CASE_SH : '0;
    pm   = l2c_plain(c);
    want = (c == "t") ? U_S : U_H;
    hit  = (c == "z") ? CYR_ZHE : (c == "k") ? CYR_HA : (c == "c") ? CYR_CHE : CYR_TSE;
    miss = (c == "z") ? CYR_ZE : (c == "t") ? CYR_TE : CYR_KA;

    if (!up && !lo) begin
      // not an ASCII letter: pass through
      r.e0 = q[0];
    end else if (pm != '0) begin
      r.e0 = unit_t'(pm - sh);
    end else begin
      unique case (c)
        "e": begin
          r.e0 = unit_t'((first ? CYR_E_REV : CYR_IE) - sh);
        end
        "z", "k", "c", "t": begin
          if (!av1) begin
            r.used = 3'd0;
            r.n    = 2'd0;
          end else if (f1 == want) begin
            r.e0   = unit_t'(hit - sh);
            r.used = 3'd2;
          end else begin
            r.e0 = unit_t'(miss - sh);
          end
        end
        "s": begin
          priority if (!av1) begin
            r.used = 3'd0;
            r.n    = 2'd0;
          end else if (f1 != U_H) begin
            r.e0 = unit_t'(CYR_ES - sh);
          end else if (!av2) begin
            r.used = 3'd0;
            r.n    = 2'd0;
          end else if (f2 != U_C) begin
            r.e0   = unit_t'(CYR_SHA - sh);
            r.used = 3'd2;
          end else if (!av3) begin
            r.used = 3'd0;
            r.n    = 2'd0;
          end else if (f3 == U_H) begin
            r.e0   = unit_t'(CYR_SHCHA - sh);
            r.used = 3'd4;
          end else begin
            r.e0   = unit_t'(CYR_SHA - sh);
            r.used = 3'd2;
          end
        end
        "x": begin
          priority if (!up) begin
            r.e0 = CYR_KA;
            r.e1 = CYR_ES;
            r.n  = 2'd2;
          end else if (!av1) begin
            r.used = 3'd0;
            r.n    = 2'd0;
          end else begin
            r.e0 = CYR_UP_KA;
            r.e1 = low1 ? CYR_ES : CYR_UP_ES;
            r.n  = 2'd2;
          end
        end
        "y": begin
          priority if (!av1) begin
            r.used = 3'd0;
            r.n    = 2'd0;
          end else if (f1 == U_E) begin
            r.e0   = unit_t'(CYR_IE - sh);
            r.used = 3'd2;
          end else if (f1 == U_O) begin
            r.e0   = up ? CYR_UP_YO : CYR_YO;
            r.used = 3'd2;
          end else if (f1 == U_U) begin
            r.e0   = unit_t'(CYR_YU - sh);
            r.used = 3'd2;
          end else if (f1 == U_A) begin
            r.e0   = unit_t'(CYR_YA - sh);
            r.used = 3'd2;
          end else if (f1 == U_I) begin
            r.e0 = unit_t'(CYR_SOFT - sh);
          end else if (f1 == U_NUL || f1 == U_SPACE || f1 == U_STOP) begin
            r.e0 = unit_t'(CYR_I - sh);
            r.e1 = unit_t'(CYR_SHORT - sh);
            r.n  = 2'd2;
          end else begin
            r.e0 = unit_t'(CYR_YERU - sh);
          end
        end
        default: begin
          // h, j, q and w standing alone pass through
          r.e0 = q[0];
        end
      endcase
    end
    return r;
  endfunction

endpackage

@@ design/latin_to_cyrillic_transliterator.sv @@
// Latin to Cyrillic transliterator: input register, decision logic, result register.
// The input register holds an item until it is decided; its results then load the
// result register, from where the first of them is offered on the output port.
// Throughput: one item per cycle while each item yields at most one result and the
// output does not stall; an item with several results holds the result register
// until its last one has transferred. Items that only wait in the lookahead buffer yield nothing.
// Reset clears the handshake state and the pending count and sets string start;
// the lookahead buffer is not cleared.
module latin_to_cyrillic_transliterator
  import l2c_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] code_unit_i,
  input  logic        string_end_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] out_unit_o,
  output logic        run_last_o,
  output logic        string_done_o
);

  // Input register
  logic        in_valid_q, in_valid_d;
  unit_t       in_unit_q;
  logic        in_end_q;
  logic        in_xfer;

  // Lookahead state
  unit_t       buf_q [3];
  logic [1:0]  pend_q, pend_d;
  logic        start_q, start_d;

  // Result register
  win_t        res_q;
  logic [2:0]  res_cnt_q, res_cnt_d;
  logic [1:0]  res_idx_q, res_idx_d;
  logic        res_end_q;

  // Decision logic
  win_t        win;
  logic [2:0]  wn;
  logic        first;
  logic        stop;
  dec_t        dec;
  logic [2:0]  used;
  win_t        ebuf;
  logic [2:0]  ecnt;

  logic        fire;
  logic        out_xfer;
  logic        out_last_xfer;

  // Handshake
  assign out_valid_o   = (res_cnt_q != 3'd0);
  assign out_unit_o    = res_q[res_idx_q];
  assign run_last_o    = ({1'b0, res_idx_q} == 3'(res_cnt_q - 3'd1));
  assign string_done_o = run_last_o && res_end_q;
  assign out_xfer      = out_valid_o && !out_stall_i;
  assign out_last_xfer = out_xfer && run_last_o;
  assign fire          = in_valid_q && ((res_cnt_q == 3'd0) || out_last_xfer);
  assign in_stall_o    = in_valid_q && !fire;
  assign in_xfer       = in_valid_i && !in_stall_o;

  // Decide every unit of the window that can be decided, head first
  always_comb begin
    win   = '0;
    for (int i = 0; i < 3; i++) begin
      if (i < int'(pend_q)) begin
        win[i] = buf_q[i];
      end
    end
    win[pend_q] = in_unit_q;
    wn    = {1'b0, pend_q} + 3'd1;
    first = start_q;
    stop  = 1'b0;
    ebuf  = '0;
    ecnt  = 3'd0;
    dec   = '0;
    used  = 3'd0;
    for (int s = 0; s < 4; s++) begin
      if (!stop && wn != 3'd0) begin
        dec = l2c_decide(win, wn, in_end_q, first);
        if (dec.used == 3'd0) begin
          stop = 1'b1;
        end else begin
          if (dec.n != 2'd0 && ecnt != 3'd4) begin
            ebuf[ecnt[1:0]] = dec.e0;
            ecnt = ecnt + 3'd1;
          end
          if (dec.n == 2'd2 && ecnt != 3'd4) begin
            ebuf[ecnt[1:0]] = dec.e1;
            ecnt = ecnt + 3'd1;
          end
          first = 1'b0;
          used  = (dec.used > wn) ? wn : dec.used;
          win   = win_t'(win >> {used, 4'b0000});
          wn    = wn - used;
        end
      end
    end
  end

  // Next control state
  always_comb begin
    in_valid_d = in_valid_q;
    if (in_xfer) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end

    pend_d  = pend_q;
    start_d = start_q;
    if (fire) begin
      if (in_end_q) begin
        pend_d  = 2'd0;
        start_d = 1'b1;
      end else begin
        pend_d  = wn[1:0];
        start_d = first;
      end
    end

    res_cnt_d = res_cnt_q;
    res_idx_d = res_idx_q;
    if (fire) begin
      res_cnt_d = ecnt;
      res_idx_d = 2'd0;
    end else if (out_last_xfer) begin
      res_cnt_d = 3'd0;
      res_idx_d = 2'd0;
    end else if (out_xfer) begin
      res_idx_d = res_idx_q + 2'd1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      pend_q     <= 2'd0;
      start_q    <= 1'b1;
      res_cnt_q  <= 3'd0;
      res_idx_q  <= 2'd0;
    end else begin
      in_valid_q <= in_valid_d;
      pend_q     <= pend_d;
      start_q    <= start_d;
      res_cnt_q  <= res_cnt_d;
      res_idx_q  <= res_idx_d;
    end
  end

  // Payload registers: hold unless a transfer or a decision loads them
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_unit_q <= code_unit_i;
      in_end_q  <= string_end_i;
    end
    if (fire) begin
      res_q     <= ebuf;
      res_end_q <= in_end_q;
      if (!in_end_q) begin
        for (int i = 0; i < 3; i++) begin
          buf_q[i] <= win[i];
        end
      end
    end
  end

  // The read index stays inside the loaded results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, res_idx_q} < res_cnt_q))
    else $error("result index beyond result count");

  // A string's last unit always leaves at least one result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_end_q) |-> (ecnt != 3'd0))
    else $error("string end produced no result");

  // String end empties the buffer and rearms string start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_end_q) |=> (pend_q == 2'd0) && start_q)
    else $error("buffer not flushed at string end");

  // String done only marks the last result of an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    string_done_o |-> run_last_o)
    else $error("string done without run last");

endmodule
